/* hw/rtl/smr_pkg.sv */
// shared constants and types for the row softmax block
package smr_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned ExpW   = 16;
  localparam int unsigned SumW   = 23;
  localparam int unsigned ProdW  = 32;

  typedef logic [ExpW-1:0] pow_tab_t [16];

  localparam pow_tab_t PowTab = '{
    16'd65535, 16'd62757, 16'd60097, 16'd57549, 16'd55109, 16'd52773, 16'd50535, 16'd48393,
    16'd46341, 16'd44376, 16'd42495, 16'd40693, 16'd38968, 16'd37316, 16'd35734, 16'd34219
  };

  // exp(-d/256) in q0.16 by table and shift
  function automatic logic [ExpW-1:0] exp_neg(input logic [ScoreW-1:0] d);
    logic [ScoreW+8:0] t;
    logic [ExpW-1:0]   r;
    t = {9'd0, d} * 25'd369;
    if (t[24:20] != 5'd0) begin
      r = '0;
    end else begin
      r = PowTab[t[15:12]] >> t[19:16];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/smr_div.sv */
// restoring divider, one quotient bit per cycle
module smr_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [smr_pkg::ProdW-1:0] num_i,
  input  logic [smr_pkg::SumW-1:0]  den_i,
  output logic                     done_o,
  output logic [smr_pkg::ProdW-1:0] quo_o
);

  logic [smr_pkg::ProdW-1:0] quo_q, quo_d;
  logic [smr_pkg::SumW:0]    rem_q, rem_d;
  logic [smr_pkg::SumW-1:0]  den_q;
  logic [5:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [smr_pkg::SumW:0]    trial;
  logic [smr_pkg::SumW+1:0]  diff;

  always_comb begin
    trial  = {rem_q[smr_pkg::SumW-1:0], quo_q[smr_pkg::ProdW-1]};
    diff   = {1'b0, trial} - {2'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[smr_pkg::SumW+1]) begin
        rem_d = diff[smr_pkg::SumW:0];
        quo_d = {quo_q[smr_pkg::ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[smr_pkg::ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(smr_pkg::ProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : quo_q;

endmodule

/* hw/rtl/softmax_row.sv */
// row softmax top level: buffers a row, then exponent and divide passes
// load: one score per cycle; a row closes on last_in or after MAX_ROW_LEN scores
// exponent pass: one memory read per score from the score memory
// divide pass: bit-serial 32-bit divider; the next result starts once the last one is taken
// results leave through an output register; input stalls until the row is delivered
// async active-low reset clears control state; the memories are not cleared
module softmax_row #(
  parameter int unsigned MAX_ROW_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] score_i,
  input  logic        last_in_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] prob_o,
  output logic        last_out_o
);

  localparam int unsigned AW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_ROW_LEN + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [15:0] score_mem [MAX_ROW_LEN];
  logic [15:0] exp_mem   [MAX_ROW_LEN];

  logic [2:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic signed [15:0] max_q, max_d;
  logic [smr_pkg::SumW-1:0] sum_q, sum_d;
  logic        rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [15:0] score_rd_q, exp_rd_q;
  logic [smr_pkg::ProdW-1:0] prod;
  logic        div_start, div_done;
  logic [smr_pkg::ProdW-1:0] quo;
  logic        vld_q, last_q;
  logic [15:0] prob_q;
  logic        in_acc, out_acc, closes;
  logic [15:0] diff;
  logic [15:0] e_val;

  assign in_acc  = valid_i && !stall_o;
  assign out_acc = vld_q && !stall_i;
  assign stall_o = (st_q != StLoad);
  assign closes  = last_in_i || (cnt_q == CW'(MAX_ROW_LEN - 1));
  assign diff    = 16'(max_q - $signed(score_rd_q));
  assign e_val   = smr_pkg::exp_neg(diff);
  assign div_start = (st_q == StMul);
  assign prod    = {16'd0, exp_rd_q} * 32'd65535;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    max_d = max_q;
    sum_d = sum_q;
    unique case (st_q)
      StLoad: begin
        if (in_acc) begin
          cnt_d = cnt_q + CW'(1);
          if ($signed(score_i) > max_q) max_d = $signed(score_i);
          if (closes) begin
            st_d  = StExp;
            idx_d = '0;
            sum_d = '0;
          end
        end
      end
      StExp: begin
        if (idx_q != cnt_q) idx_d = idx_q + CW'(1);
        if (rd_vld_q) sum_d = sum_q + smr_pkg::SumW'(e_val);
        if (idx_q == cnt_q && !rd_vld_q) begin
          st_d  = StRd;
          idx_d = '0;
        end
      end
      StRd:  st_d = StMul;
      StMul: st_d = StDiv;
      StDiv: if (div_done) st_d = StOut;
      StOut: begin
        if (!vld_q || out_acc) begin
          if (idx_q == cnt_q - CW'(1)) begin
            st_d  = StLoad;
            cnt_d = '0;
            max_d = 16'sh8000;
            sum_d = '0;
          end else begin
            idx_d = idx_q + CW'(1);
            st_d  = StRd;
          end
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StLoad;
      cnt_q    <= '0;
      idx_q    <= '0;
      max_q    <= 16'sh8000;
      sum_q    <= '0;
      rd_vld_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      max_q    <= max_d;
      sum_q    <= sum_d;
      rd_vld_q <= (st_q == StExp) && (idx_q != cnt_q);
      if (st_q == StDiv && div_done) begin
        vld_q <= 1'b1;
      end else if (out_acc) begin
        vld_q <= 1'b0;
      end
    end
  end

  // memories, synchronous read
  always_ff @(posedge clk_i) begin
    if (in_acc) score_mem[cnt_q[AW-1:0]] <= score_i;
    score_rd_q <= score_mem[idx_q[AW-1:0]];
    rd_idx_q   <= idx_q[AW-1:0];
    if (rd_vld_q) exp_mem[rd_idx_q] <= e_val;
    exp_rd_q   <= exp_mem[idx_q[AW-1:0]];
  end

  smr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      prob_q <= (quo > 32'd65535) ? 16'hFFFF : quo[15:0];
      last_q <= (idx_q == cnt_q - CW'(1));
    end
  end

  assign valid_o    = vld_q;
  assign prob_o     = prob_q;
  assign last_out_o = last_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StLoad) |-> !in_acc) else $error("input beat taken while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ROW_LEN)) else $error("row count overflow");
  a_out_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (st_q == StOut || st_q == StRd || st_q == StLoad))
    else $error("result held outside output phase");
  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRd) |-> (sum_q >= 23'd65535)) else $error("row sum too small");

endmodule

/* verif/softmax_row_tb.sv */
// self-checking testbench for the row softmax block: directed table, a full-length row, then random rows
module softmax_row_tb;

  localparam int unsigned RowLen = 64;

  typedef struct packed {
    logic [15:0] prob;
    logic        last;
  } prob_beat_t;

  typedef struct {
    logic [15:0] score;
    logic        last;
    logic        chk;
    logic [15:0] prob;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [15:0] score_i;
  logic        last_in_i;
  logic        valid_o;
  logic        stall_i;
  logic [15:0] prob_o;
  logic        last_out_o;

  softmax_row #(.MAX_ROW_LEN(RowLen)) u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .score_i, .last_in_i,
    .valid_o, .stall_i, .prob_o, .last_out_o
  );

  logic [15:0] pow_lut [16] = '{
    16'd65535, 16'd62757, 16'd60097, 16'd57549, 16'd55109, 16'd52773, 16'd50535,
    16'd48393, 16'd46341, 16'd44376, 16'd42495, 16'd40693, 16'd38968, 16'd37316,
    16'd35734, 16'd34219
  };

  logic signed [15:0] row_buf [RowLen];
  logic signed [16:0] cur_max;
  int unsigned        cur_len;
  prob_beat_t         prob_q [$];
  int                 fixed_q [$];
  int unsigned        errors;
  bit                 quiet;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] exp_of_gap(logic [15:0] d);
    logic [31:0] t;
    t = {16'd0, d} * 32'd369;
    if ((t >> 16) >= 16) return 16'd0;
    return pow_lut[t[15:12]] >> t[19:16];
  endfunction

  task automatic predict_score(logic [15:0] s, logic lst);
    logic [15:0] ev [RowLen];
    logic [22:0] sum;
    logic [47:0] p;
    row_buf[cur_len] = s;
    if ($signed(s) > cur_max) cur_max = $signed(s);
    cur_len++;
    if (!lst && cur_len < RowLen) return;
    sum = '0;
    for (int i = 0; i < cur_len; i++) begin
      ev[i] = exp_of_gap(16'(cur_max - row_buf[i]));
      sum = sum + ev[i];
    end
    for (int i = 0; i < cur_len; i++) begin
      p = (sum == 0) ? 48'd0 : (48'(ev[i]) * 48'd65535) / sum;
      if (p > 48'd65535) p = 48'd65535;
      prob_q.push_back('{prob: p[15:0], last: (i == cur_len - 1)});
    end
    cur_max = -17'sd32768;
    cur_len = 0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  int unsigned gap_in;
  int unsigned gap_out;

  // sender
  task automatic send(logic [15:0] s, logic lst);
    if (!quiet && gap_in == 0 && $urandom_range(0, 5) == 0) gap_in = $urandom_range(1, 7);
    while (gap_in != 0) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
      gap_in--;
    end
    valid_i   <= 1'b1;
    score_i   <= s;
    last_in_i <= lst;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    predict_score(s, lst);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver stall and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (prob_q.size() == 0) begin
          report("unexpected beat", prob_o, 0);
        end else begin
          prob_beat_t exp_b;
          int fx;
          exp_b = prob_q.pop_front();
          fx = fixed_q.size() ? fixed_q.pop_front() : -1;
          if (fx >= 0 && exp_b.prob != fx[15:0]) report("table prob", exp_b.prob, fx);
          if (prob_o !== exp_b.prob) report("prob", prob_o, exp_b.prob);
          if (last_out_o !== exp_b.last) report("last", last_out_o, exp_b.last);
        end
      end
      if (quiet) begin
        stall_i <= 1'b0;
      end else if (gap_out != 0) begin
        gap_out <= gap_out - 1;
        stall_i <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        gap_out <= $urandom_range(0, 6);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end else begin
      stall_i <= 1'b0;
      gap_out <= 0;
    end
  end

  stim_row_t dir_tab [] = '{
    '{16'h0000, 1'b1, 1'b1, 16'd65535},
    '{16'h7fff, 1'b1, 1'b1, 16'd65535},
    '{16'h8000, 1'b1, 1'b1, 16'd65535},
    '{16'h8000, 1'b0, 1'b1, 16'd0},
    '{16'h7fff, 1'b1, 1'b1, 16'd65535},
    '{16'h0100, 1'b0, 1'b1, 16'd32767},
    '{16'h0100, 1'b1, 1'b1, 16'd32767},
    '{16'h0000, 1'b0, 1'b0, 16'd0},
    '{16'h0100, 1'b0, 1'b0, 16'd0},
    '{16'hff00, 1'b0, 1'b0, 16'd0},
    '{16'h0080, 1'b1, 1'b0, 16'd0},
    '{16'h5555, 1'b0, 1'b0, 16'd0},
    '{16'haaaa, 1'b0, 1'b0, 16'd0},
    '{16'h5500, 1'b1, 1'b0, 16'd0}
  };

  initial begin
    logic [15:0] base;
    int n;
    errors = 0; quiet = 0; gap_in = 0;
    cur_max = -17'sd32768; cur_len = 0;
    rst_ni = 1'b0; valid_i = 1'b0; score_i = '0; last_in_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // one table entry per beat, results come back in input order
    foreach (dir_tab[k]) begin
      fixed_q.push_back(dir_tab[k].chk ? int'(dir_tab[k].prob) : -1);
      send(dir_tab[k].score, dir_tab[k].last);
    end
    drain();
    // full row without last flag closes at the row limit
    for (int i = 0; i < RowLen; i++) send(16'($urandom), 1'b0);
    drain();
    // random rows, mostly short, scores near a common base
    n = 0;
    while (n < 52) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, RowLen) : $urandom_range(1, 6);
      if (len > 52 - n) len = 52 - n;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        logic [15:0] s;
        s = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : base + 16'($urandom_range(0, 3000)) - 16'd1500;
        if (n > 40) quiet = 1;
        send(s, i == len - 1);
        n++;
      end
      if (n > 20 && n < 30) drain();
    end
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

endmodule
